### hdl/dleq_pkg.sv
package dleq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int LINE_COUNT  = 16;

	localparam int IDX_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH);
	localparam int LINE_W   = 4;
	localparam int LCMP_W   = 6;
	localparam int OP_W     = 2;
	localparam int QCNT_W   = 4;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// input op codes
	localparam logic [OP_W-1:0] OP_EVENT = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
	localparam logic [OP_W-1:0] OP_DEQ   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd10;

	// classified command kinds
	localparam logic [2:0] CMD_NOP  = 3'd0;
	localparam logic [2:0] CMD_PUSH = 3'd1;
	localparam logic [2:0] CMD_KEY  = 3'd2;
	localparam logic [2:0] CMD_TICK = 3'd3;
	localparam logic [2:0] CMD_DEQ  = 3'd4;

	typedef struct packed {
		logic [2:0]        kind;
		logic [LINE_W-1:0] line;
	} dleq_cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] line_enable_mask;
		logic [CFG_W-1:0] key_mask;
		logic [CFG_W-1:0] debounce_ticks;
	} dleq_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dleq_fifo_stat_t;

endpackage

### hdl/dleq_in_if.sv
interface dleq_in_if import dleq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [LINE_W-1:0] line;

	modport source (output valid, output op, output line, input ready);
	modport sink (input valid, input op, input line, output ready);
endinterface

### hdl/dleq_out_if.sv
interface dleq_out_if import dleq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              deq_valid;
	logic [LINE_W-1:0] deq_line;
	logic              dropped;
	logic [QCNT_W-1:0] queue_count;

	modport source (output valid, output deq_valid, output deq_line, output dropped,
		output queue_count, input ready);
	modport sink (input valid, input deq_valid, input deq_line, input dropped,
		input queue_count, output ready);
endinterface

### hdl/dleq_front.sv
module dleq_front import dleq_pkg::*; (
	dleq_in_if.sink    evt,
	input  dleq_cfg_t  cfg,
	output logic       cmd_valid,
	output dleq_cmd_t  cmd,
	input  logic       cmd_ready
);

	logic line_ok;

	assign evt.ready = cmd_ready;
	assign cmd_valid = evt.valid;

	// line in range and enabled
	assign line_ok = (LCMP_W'(evt.line) < LCMP_W'(LINE_COUNT)) &&
		cfg.line_enable_mask[evt.line];

	always_comb begin
		cmd.line = evt.line;
		case (evt.op)
			OP_EVENT: begin
				if (!line_ok) cmd.kind = CMD_NOP;
				else if (cfg.key_mask[evt.line]) cmd.kind = CMD_KEY;
				else cmd.kind = CMD_PUSH;
			end
			OP_TICK: cmd.kind = CMD_TICK;
			OP_DEQ:  cmd.kind = CMD_DEQ;
			default: cmd.kind = CMD_NOP;
		endcase
	end

endmodule

### hdl/dleq_cmd_fifo.sv
module dleq_cmd_fifo import dleq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dleq_cmd_t       push_cmd,
	input  logic            pop,
	output dleq_cmd_t       pop_cmd,
	output dleq_fifo_stat_t stat
);

	dleq_cmd_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

### hdl/dleq_back.sv
module dleq_back import dleq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dleq_cfg_t  cfg,
	input  logic       cmd_valid,
	input  dleq_cmd_t  cmd,
	output logic       cmd_ready,
	dleq_out_if.source res
);

	logic [LINE_W-1:0] ring_q [QUEUE_DEPTH];
	logic [IDX_W-1:0]  head_q, tail_q, head_n, tail_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic              pend_v_q, pend_v_n;
	logic [LINE_W-1:0] pend_ln_q, pend_ln_n;
	logic [CFG_W-1:0]  dcnt_q, dcnt_n, dcnt_inc, limit;
	logic              run_q, run_n;

	logic              fire;
	logic              push_req;
	logic [LINE_W-1:0] push_ln;
	logic              ring_we;
	logic              r_deq_valid, r_dropped;
	logic [LINE_W-1:0] r_deq_line;

	logic              out_valid_q;
	logic              deq_valid_q, dropped_q;
	logic [LINE_W-1:0] deq_line_q;
	logic [QCNT_W-1:0] queue_count_q;

	assign cmd_ready = !out_valid_q || res.ready;
	assign fire      = cmd_valid && cmd_ready;

	// zero ticks acts as one
	assign limit    = (cfg.debounce_ticks == '0) ? CFG_W'(1) : cfg.debounce_ticks;
	assign dcnt_inc = dcnt_q + CFG_W'(1);

	always_comb begin
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		pend_v_n    = pend_v_q;
		pend_ln_n   = pend_ln_q;
		dcnt_n      = dcnt_q;
		run_n       = run_q;
		push_req    = 1'b0;
		push_ln     = cmd.line;
		ring_we     = 1'b0;
		r_deq_valid = 1'b0;
		r_deq_line  = '0;
		r_dropped   = 1'b0;

		case (cmd.kind)
			CMD_PUSH: push_req = 1'b1;
			CMD_KEY: begin
				pend_v_n  = 1'b1;
				pend_ln_n = cmd.line;
				dcnt_n    = '0;
				run_n     = 1'b1;
			end
			CMD_TICK: begin
				if (run_q) begin
					if (dcnt_inc >= limit) begin
						run_n  = 1'b0;
						dcnt_n = '0;
						if (pend_v_q) begin
							push_req = 1'b1;
							push_ln  = pend_ln_q;
							pend_v_n = 1'b0;
						end
					end else begin
						dcnt_n = dcnt_inc;
					end
				end
			end
			CMD_DEQ: begin
				if (count_q != '0) begin
					r_deq_valid = 1'b1;
					r_deq_line  = ring_q[head_q];
					head_n  = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_n = count_q - 1'b1;
				end
			end
			default: ;
		endcase

		// ring holds one fewer than its depth; a full ring refuses
		if (push_req) begin
			if (count_q == CNT_W'(QUEUE_DEPTH - 1)) begin
				r_dropped = 1'b1;
			end else begin
				ring_we = 1'b1;
				tail_n  = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_n = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pend_v_q    <= 1'b0;
			dcnt_q      <= '0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				head_q   <= head_n;
				tail_q   <= tail_n;
				count_q  <= count_n;
				pend_v_q <= pend_v_n;
				dcnt_q   <= dcnt_n;
				run_q    <= run_n;
			end
			if (fire) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_ln_q     <= pend_ln_n;
			deq_valid_q   <= r_deq_valid;
			deq_line_q    <= r_deq_line;
			dropped_q     <= r_dropped;
			queue_count_q <= QCNT_W'(count_n);
		end
		if (fire && ring_we) ring_q[tail_q] <= push_ln;
	end

	assign res.valid       = out_valid_q;
	assign res.deq_valid   = deq_valid_q;
	assign res.deq_line    = deq_line_q;
	assign res.dropped     = dropped_q;
	assign res.queue_count = queue_count_q;

endmodule

### hdl/debounced_line_event_queue.sv
// Debounced line event queue. Each request on evt carries an op (line event, timer tick,
// dequeue, or no-op) and a line number, and produces exactly one result on res: the popped
// line with deq_valid, a dropped flag when an enqueue met a full ring, and the ring fill after
// the request. Plain enabled lines are queued at once; key lines sit in a single pending slot
// that is queued once debounce_ticks ticks pass without a newer key event. The ring keeps
// QUEUE_DEPTH-1 lines and never overwrites. Sustained rate is one request per clock while res
// is ready; a stall on res holds the result. The accepting edge writes the classified request
// into a two-entry command queue, from which the back part, which owns the ring, pointers and
// debounce counter, takes it and writes the result register.
// Configuration writes go through cfg_we/cfg_idx/cfg_data and
// must only happen while no request is in flight; there is no reset sweep of the ring.
module debounced_line_event_queue import dleq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	dleq_in_if.sink              evt,
	dleq_out_if.source           res
);

	dleq_cfg_t       cfg_q;
	logic            front_valid;
	dleq_cmd_t       front_cmd;
	dleq_cmd_t       back_cmd;
	logic            back_ready;
	dleq_fifo_stat_t fifo_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_enable_mask <= '0;
			cfg_q.key_mask         <= '0;
			cfg_q.debounce_ticks   <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LINE_ENABLE: cfg_q.line_enable_mask <= cfg_data;
				REG_KEY_MASK:    cfg_q.key_mask         <= cfg_data;
				REG_DEBOUNCE:    cfg_q.debounce_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify against the masks
	dleq_front u_front (
		.evt       (evt),
		.cfg       (cfg_q),
		.cmd_valid (front_valid),
		.cmd       (front_cmd),
		.cmd_ready (!fifo_stat.full)
	);

	// short command queue decouples the two sides
	dleq_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.push_cmd (front_cmd),
		.pop      (back_ready),
		.pop_cmd  (back_cmd),
		.stat     (fifo_stat)
	);

	// back: ring, pending key slot, debounce timer, result register
	dleq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (!fifo_stat.empty),
		.cmd       (back_cmd),
		.cmd_ready (back_ready),
		.res       (res)
	);

	// a refused enqueue leaves the ring full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.dropped |-> res.queue_count == QCNT_W'(QUEUE_DEPTH - 1))
		else $error("drop reported with ring not full");

	// one request never both pops and drops
	a_drop_deq: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.dropped |-> !res.deq_valid)
		else $error("drop and dequeue in one result");

	// a result without a dequeue, empty ones included, reports line zero
	a_deq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.deq_valid |-> res.deq_line == '0)
		else $error("line reported without dequeue");

endmodule

### tb/sv/tb_debounced_line_event_queue.sv
`timescale 1ns / 1ps

module tb_debounced_line_event_queue;
	import dleq_pkg::*;

	// the package has no name for the fourth op code, which does nothing
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_REQS = 193;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LINE_W-1:0] line;
	} req_t;

	typedef struct packed {
		logic              deq_valid;
		logic [LINE_W-1:0] deq_line;
		logic              dropped;
		logic [QCNT_W-1:0] queue_count;
	} res_t;

	logic clk = 1'b0;
	// starts high so that the assertion below is a real falling edge
	logic arst_n = 1'b1;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_LINE_ENABLE;
	logic [CFG_W-1:0] cfg_data = '0;

	dleq_in_if evt_if ();
	dleq_out_if res_if ();

	debounced_line_event_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.evt      (evt_if.sink),
		.res      (res_if.source)
	);

	always #5 clk = ~clk;

	// requests waiting to be sent, and results predicted for accepted requests
	req_t req_backlog[$];
	res_t predicted_res[$];
	int err_cnt = 0;
	int cycle_cnt = 0;
	bit gaps_on = 1'b1;
	int src_gap = 0;
	int snk_gap = 0;
	req_t next_req;
	res_t got_res;
	res_t want_res;

	// shadow of the block: configuration
	logic [CFG_W-1:0] shadow_enable = '0;
	logic [CFG_W-1:0] shadow_keys = '0;
	logic [CFG_W-1:0] shadow_debounce = DEBOUNCE_RESET;

	// shadow of the block: ring, pointers and debounce timer
	logic [LINE_W-1:0] ring_lines [QUEUE_DEPTH];
	int ring_head = 0;
	int ring_tail = 0;
	int key_waiting = LINE_COUNT;
	logic [CFG_W-1:0] tick_count = '0;
	bit timer_armed = 1'b0;

	function automatic int ring_fill();
		return (ring_tail + QUEUE_DEPTH - ring_head) % QUEUE_DEPTH;
	endfunction

	// returns 1 when the ring is full and the line is thrown away
	function automatic bit ring_push(int ln);
		if (ring_fill() >= QUEUE_DEPTH - 1)
			return 1'b1;
		ring_lines[ring_tail] = ln[LINE_W-1:0];
		ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
		return 1'b0;
	endfunction

	// advance the shadow by one request and return the result it yields
	function automatic res_t step_event_queue(req_t r);
		res_t o;
		logic [CFG_W-1:0] expiry;
		int ln;
		o = '0;
		ln = int'(r.line);
		case (r.op)
			OP_EVENT: begin
				// lines without a handler are ignored outright
				if (ln < LINE_COUNT && shadow_enable[ln]) begin
					if (shadow_keys[ln]) begin
						// a key replaces any waiting key and restarts the timer
						key_waiting = ln;
						tick_count = '0;
						timer_armed = 1'b1;
					end else begin
						o.dropped = ring_push(ln);
					end
				end
			end
			OP_TICK: begin
				if (timer_armed) begin
					// a zero setting acts as one tick
					expiry = (shadow_debounce == '0) ? CFG_W'(1) : shadow_debounce;
					tick_count = tick_count + 1'b1;
					if (tick_count >= expiry) begin
						timer_armed = 1'b0;
						tick_count = '0;
						if (key_waiting < LINE_COUNT) begin
							// the slot empties even when the push is refused
							o.dropped = ring_push(key_waiting);
							key_waiting = LINE_COUNT;
						end
					end
				end
			end
			OP_DEQ: begin
				if (ring_fill() != 0) begin
					o.deq_valid = 1'b1;
					o.deq_line = ring_lines[ring_head];
					ring_head = (ring_head + 1) % QUEUE_DEPTH;
				end
			end
			default: ;
		endcase
		o.queue_count = QCNT_W'(ring_fill());
		return o;
	endfunction

	// request driver: predicts each request as it is taken, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_if.valid <= 1'b0;
			evt_if.op <= OP_NOP;
			evt_if.line <= '0;
		end else begin
			if (evt_if.valid && evt_if.ready) begin
				next_req.op = evt_if.op;
				next_req.line = evt_if.line;
				predicted_res.push_back(step_event_queue(next_req));
			end
			if (!evt_if.valid || evt_if.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					evt_if.valid <= 1'b0;
				end else if (req_backlog.size() != 0 && gaps_on && $urandom_range(0, 9) == 0) begin
					// start a burst of idle cycles, this one included
					src_gap = $urandom_range(1, 14) - 1;
					evt_if.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					next_req = req_backlog.pop_front();
					evt_if.valid <= 1'b1;
					evt_if.op <= next_req.op;
					evt_if.line <= next_req.line;
				end else begin
					evt_if.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	// result monitor: compares against the oldest prediction, stalls in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got_res.deq_valid = res_if.deq_valid;
				got_res.deq_line = res_if.deq_line;
				got_res.dropped = res_if.dropped;
				got_res.queue_count = res_if.queue_count;
				if (predicted_res.size() == 0) begin
					$error("result with no request outstanding: deq_valid %0d deq_line %0d",
						got_res.deq_valid, got_res.deq_line);
					err_cnt++;
				end else begin
					want_res = predicted_res.pop_front();
					check_field("deq_valid", want_res.deq_valid, got_res.deq_valid);
					check_field("deq_line", want_res.deq_line, got_res.deq_line);
					check_field("dropped", want_res.dropped, got_res.dropped);
					check_field("queue_count", want_res.queue_count, got_res.queue_count);
				end
			end
			// a burst left over from an earlier phase ends once idling is off
			if (gaps_on && snk_gap > 0) begin
				snk_gap--;
				res_if.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				snk_gap = $urandom_range(1, 14) - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_req(input logic [OP_W-1:0] op, input logic [LINE_W-1:0] line);
		req_t r;
		r.op = op;
		r.line = line;
		req_backlog.push_back(r);
	endtask

	// idle means nothing queued, nothing offered and every result back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || evt_if.valid || predicted_res.size() != 0);
	endtask

	// writes all three registers on back-to-back edges
	task automatic program_regs(input logic [CFG_W-1:0] en, input logic [CFG_W-1:0] keys,
		input logic [CFG_W-1:0] ticks);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_LINE_ENABLE;
		cfg_data <= en;
		@(posedge clk);
		cfg_idx <= REG_KEY_MASK;
		cfg_data <= keys;
		@(posedge clk);
		cfg_idx <= REG_DEBOUNCE;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_enable = en;
		shadow_keys = keys;
		shadow_debounce = ticks;
		@(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] en;
		logic [CFG_W-1:0] keys;
		logic [CFG_W-1:0] ticks;
		int pick;
		int w_event;
		int w_tick;
		int w_deq;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: nothing enabled, so the event is ignored,
		// a tick with the timer stopped, a dequeue on an empty ring, a no-op
		add_req(OP_EVENT, 4'd0);
		add_req(OP_TICK, 4'hF);
		add_req(OP_DEQ, 4'd0);
		add_req(OP_NOP, 4'hA);
		wait_idle();

		// zero debounce acts as one tick; top line is a key, bottom line plain
		program_regs(16'hFFFF, 16'h8000, 16'd0);
		add_req(OP_EVENT, 4'd0);
		add_req(OP_EVENT, 4'hF);
		add_req(OP_TICK, 4'd5);
		add_req(OP_DEQ, 4'd0);
		add_req(OP_DEQ, 4'hF);
		add_req(OP_DEQ, 4'd0);
		wait_idle();

		// disabled top line, then a second key replaces the first and
		// restarts the count before it expires
		program_regs(16'h7FFF, 16'h0003, 16'd2);
		add_req(OP_EVENT, 4'hF);
		add_req(OP_EVENT, 4'd0);
		add_req(OP_TICK, 4'd0);
		add_req(OP_EVENT, 4'd1);
		add_req(OP_TICK, 4'd0);
		add_req(OP_TICK, 4'd0);
		add_req(OP_DEQ, 4'd0);
		wait_idle();

		// random phases, each with its own settings and op mix
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p % 5)
				0: begin
					en = 16'hFFFF;
					keys = 16'($urandom);
					ticks = 16'd1;
				end
				1: begin
					en = 16'($urandom) | 16'($urandom);
					keys = 16'hFFFF;
					ticks = 16'($urandom_range(2, 6));
				end
				2: begin
					en = 16'($urandom);
					keys = 16'($urandom);
					ticks = 16'hFFFF;
				end
				3: begin
					en = 16'hFFFF;
					keys = 16'h0000;
					ticks = 16'($urandom_range(1, 4));
				end
				default: begin
					en = 16'($urandom) | 16'($urandom);
					keys = 16'($urandom) & 16'($urandom);
					ticks = 16'($urandom_range(0, 8));
				end
			endcase
			program_regs(en, keys, ticks);

			// mixes: filling (ring runs full), draining, balanced
			case (p % 3)
				0: begin
					w_event = 55;
					w_tick = 25;
					w_deq = 10;
				end
				1: begin
					w_event = 20;
					w_tick = 20;
					w_deq = 55;
				end
				default: begin
					w_event = 35;
					w_tick = 30;
					w_deq = 30;
				end
			endcase
			// no idling in the closing phases
			gaps_on = (p < RAND_PHASES - 2);

			for (int i = 0; i < PHASE_REQS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < w_event)
					add_req(OP_EVENT, 4'($urandom_range(0, 15)));
				else if (pick < w_event + w_tick)
					add_req(OP_TICK, 4'($urandom_range(0, 15)));
				else if (pick < w_event + w_tick + w_deq)
					add_req(OP_DEQ, 4'($urandom_range(0, 15)));
				else
					add_req(OP_NOP, 4'($urandom_range(0, 15)));
			end
			wait_idle();
		end

		// let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
